@@ rtl/crc32ws_pkg.sv @@
// Package for the word-serial CRC-32 block: constants and the 32-bit word update.
// No dependencies.
package crc32ws_pkg;

	localparam int unsigned CrcWidth = 32;

	localparam logic [CrcWidth-1:0] CRC_POLY   = 32'h04C1_1DB7;
	localparam logic [CrcWidth-1:0] CRC_PRESET = 32'hFFFF_FFFF;

	typedef logic [CrcWidth-1:0] crc_word_t;

	// One bit step, MSB first: shift, fold the old top bit, then fold the data bit.
	function automatic crc_word_t crc_bit_step(input crc_word_t crc, input logic din);
		crc_word_t nxt;
		nxt = {crc[CrcWidth-2:0], 1'b0};
		if (crc[CrcWidth-1])
			nxt = nxt ^ CRC_POLY;
		if (din)
			nxt = nxt ^ CRC_POLY;
		return nxt;
	endfunction

	// Serial update over a whole word. Only called with constant arguments,
	// to build the columns of the linear update below.
	function automatic crc_word_t crc_word_serial(input crc_word_t crc, input crc_word_t word);
		crc_word_t acc;
		acc = crc;
		for (int k = CrcWidth - 1; k >= 0; k--)
			acc = crc_bit_step(acc, word[k]);
		return acc;
	endfunction

	// Contribution of register bit i and of data bit i to the updated register.
	function automatic crc_word_t crc_col_reg(input int i);
		return crc_word_serial(crc_word_t'(1) << i, '0);
	endfunction

	function automatic crc_word_t crc_col_data(input int i);
		return crc_word_serial('0, crc_word_t'(1) << i);
	endfunction

	// The update is linear over GF(2): XOR of constant columns selected by
	// the set bits of the register and of the data word. Flat XOR trees.
	function automatic crc_word_t crc_word_next(input crc_word_t crc, input crc_word_t word);
		crc_word_t acc;
		acc = '0;
		for (int i = 0; i < CrcWidth; i++) begin
			if (crc[i])
				acc = acc ^ crc_col_reg(i);
			if (word[i])
				acc = acc ^ crc_col_data(i);
		end
		return acc;
	endfunction

endpackage

@@ rtl/crc32_word_serial.sv @@
// Word-serial CRC-32 (poly 0x04C11DB7, MSB first, preset all ones, no final XOR).
// The word marked last is registered in stage 1, then its CRC in the output register.
// Throughput: one word per cycle; the input stalls only while a last word waits
// behind a stalled result. The 32-bit update is one XOR stage.
// Reset: asynchronous, clears the pipeline valids and presets the CRC to all ones.
// Depends on crc32ws_pkg.
module crc32_word_serial
	import crc32ws_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CrcWidth-1:0] data_word,
	input  logic                first_word,
	input  logic                last_word,

	output logic                out_valid,
	input  logic                out_stall,
	output logic [CrcWidth-1:0] crc_value
);

	logic      valid_s1;
	crc_word_t data_s1;
	logic      first_s1;
	logic      last_s1;

	crc_word_t crc_q;
	logic      out_valid_q;
	crc_word_t crc_out_q;

	logic      out_free;
	logic      adv_s1;
	crc_word_t crc_base;
	crc_word_t crc_next;

	assign out_free = !out_valid_q || !out_stall;
	// Stage 1 retires when empty, when it produces no result, or when the output slot frees.
	assign adv_s1   = !valid_s1 || !last_s1 || out_free;
	assign in_stall = !adv_s1;

	always_comb begin
		crc_base = first_s1 ? CRC_PRESET : crc_q;
		crc_next = crc_word_next(crc_base, data_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			data_s1  <= data_word;
			first_s1 <= first_word;
			last_s1  <= last_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_PRESET;
		end else if (valid_s1 && adv_s1) begin
			crc_q <= crc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && last_s1 && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1 && out_free)
			crc_out_q <= crc_next;
	end

	assign out_valid = out_valid_q;
	assign crc_value = crc_out_q;

endmodule

@@ tb/crc32_word_serial_chk.sv @@
// Scoreboard for crc32_word_serial: watches both channels, runs its own bit-serial CRC,
// and compares every result transfer. Depends on crc32ws_pkg.
`timescale 1ns / 1ps
module crc32_word_serial_chk
	import crc32ws_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [CrcWidth-1:0] data_word,
	input  logic                first_word,
	input  logic                last_word,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [CrcWidth-1:0] crc_value,
	output int                  crc_mismatches,
	output int                  crc_owed
);

	crc_word_t crc_run;          // predicted CRC register
	crc_word_t crc_due[$];       // CRCs still to come out, oldest first
	crc_word_t crc_want;
	logic      took_word, took_crc, matched;

	// MSB first: shift, fold the old top bit, then fold the data bit.
	function automatic crc_word_t crc_fold_word(input crc_word_t acc, input crc_word_t w);
		crc_word_t r;
		logic      msb;
		r = acc;
		for (int k = CrcWidth - 1; k >= 0; k--) begin
			msb = r[CrcWidth-1];
			r = r << 1;
			if (msb)
				r = r ^ CRC_POLY;
			if (w[k])
				r = r ^ CRC_POLY;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_run = CRC_PRESET;
			crc_due.delete();
			crc_mismatches <= 0;
			crc_owed <= 0;
		end else begin
			took_word = in_valid && !in_stall;
			took_crc  = out_valid && !out_stall;
			matched   = 1'b0;

			// a result here cannot belong to a word taken at this same edge
			if (took_crc) begin
				if (crc_due.size() == 0) begin
					$display("%0t crc_value: expected none, actual %h", $time, crc_value);
					crc_mismatches <= crc_mismatches + 1;
				end else begin
					crc_want = crc_due.pop_front();
					matched = 1'b1;
					if (crc_value !== crc_want) begin
						$display("%0t crc_value: expected %h, actual %h",
							$time, crc_want, crc_value);
						crc_mismatches <= crc_mismatches + 1;
					end
				end
			end

			if (took_word) begin
				if (first_word)
					crc_run = CRC_PRESET;
				crc_run = crc_fold_word(crc_run, data_word);
				if (last_word)
					crc_due.push_back(crc_run);
			end

			crc_owed <= crc_owed + int'(took_word && last_word) - int'(matched);
		end
	end

endmodule

@@ tb/tb_crc32_word_serial.sv @@
// Top of the crc32_word_serial testbench: clock, reset, word stimulus, result-side stalls,
// watchdog and verdict. Depends on crc32ws_pkg, crc32_word_serial and crc32_word_serial_chk.
`timescale 1ns / 1ps
module tb_crc32_word_serial
	import crc32ws_pkg::*;
();

	localparam int unsigned WORDS_TOTAL = 1550;
	localparam int unsigned IDLE_LIMIT  = 4000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [CrcWidth-1:0] data_word = '0;
	logic                first_word = 1'b0;
	logic                last_word = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [CrcWidth-1:0] crc_value;

	int          crc_mismatches;
	int          crc_owed;
	int unsigned words_sent = 0;
	int unsigned send_gap_pct = 28;
	int unsigned recv_stall_pct = 70;
	int unsigned quiet_cycles = 0;

	always #4 clk = ~clk;

	crc32_word_serial dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_word  (data_word),
		.first_word (first_word),
		.last_word  (last_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.crc_value  (crc_value)
	);

	crc32_word_serial_chk u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_word      (data_word),
		.first_word     (first_word),
		.last_word      (last_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.crc_value      (crc_value),
		.crc_mismatches (crc_mismatches),
		.crc_owed       (crc_owed)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// ends the run when no transfer happens on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("tb_crc32_word_serial: done, errors");
				$finish;
			end
		end
	end

	function automatic crc_word_t pick_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return crc_word_t'(1) << $urandom_range(CrcWidth - 1);
			3: return ~(crc_word_t'(1) << $urandom_range(CrcWidth - 1));
			default: return $urandom;
		endcase
	endfunction

	// holds the word until the transfer happens
	task automatic send_word(input crc_word_t w, input logic f, input logic l);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_word  <= w;
		first_word <= f;
		last_word  <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (crc_owed != 0)
			@(posedge clk);
	endtask

	initial begin : stim
		int unsigned msg_len;
		logic        noisy;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no first word since reset, then continuing after a last word without a new first
		send_word('0, 1'b0, 1'b0);
		send_word('1, 1'b0, 1'b1);
		send_word(32'h8000_0000, 1'b0, 1'b1);
		// one-word messages
		send_word('0, 1'b1, 1'b1);
		send_word('1, 1'b1, 1'b1);
		send_word(32'h0000_0001, 1'b1, 1'b1);
		send_word(32'h8000_0000, 1'b1, 1'b1);
		send_word(CRC_POLY, 1'b1, 1'b1);
		// multi-word messages
		send_word(32'hA5A5_A5A5, 1'b1, 1'b0);
		send_word(32'h5A5A_5A5A, 1'b0, 1'b0);
		send_word(32'hFFFF_0000, 1'b0, 1'b1);
		send_word('0, 1'b1, 1'b0);
		send_word('0, 1'b0, 1'b1);

		while (words_sent < WORDS_TOTAL) begin
			if (send_gap_pct == 28 && words_sent >= WORDS_TOTAL / 3) begin
				drain_results();
				send_gap_pct = 70;
				recv_stall_pct <= 28;
			end else if (send_gap_pct == 70 && words_sent >= 2 * WORDS_TOTAL / 3) begin
				drain_results();
				send_gap_pct = 0;
				recv_stall_pct <= 0;
			end
			noisy = ($urandom_range(7) == 0);
			msg_len = ($urandom_range(19) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
			for (int j = 0; j < msg_len; j++) begin
				if (noisy)
					send_word(pick_word(), $urandom_range(3) == 0, $urandom_range(3) == 0);
				else
					send_word(pick_word(), j == 0, j == msg_len - 1);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (crc_mismatches == 0)
			$display("tb_crc32_word_serial: done, clean");
		else
			$display("tb_crc32_word_serial: done, errors");
		$finish;
	end

endmodule
